// ===== design/itrt_pkg.sv =====
package itrt_pkg;

    localparam int RADIX_W = 6;
    localparam int SYMBOL_W = 7;
    localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);
    localparam logic [RADIX_W-1:0] RADIX_DEFAULT = RADIX_W'(10);
    localparam logic [SYMBOL_W-1:0] CHAR_MINUS = SYMBOL_W'(8'h2D);
    localparam logic [SYMBOL_W-1:0] CHAR_ZERO = SYMBOL_W'(8'h30);
    localparam logic [SYMBOL_W-1:0] CHAR_ALPHA = SYMBOL_W'(8'h41);

    typedef struct packed {
        logic load;
        logic step;
        logic push;
        logic emit_sign;
        logic emit_digit;
    } cmd_t;

    typedef struct packed {
        logic quot_zero;
        logic negative;
        logic stack_one;
        logic out_free;
    } status_t;

    function automatic logic [SYMBOL_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] d);
        logic [SYMBOL_W-1:0] code;
        if (d < RADIX_DEFAULT) begin
            code = CHAR_ZERO + SYMBOL_W'(d);
        end else begin
            code = CHAR_ALPHA + SYMBOL_W'(d - RADIX_DEFAULT);
        end
        return code;
    endfunction

endpackage

// ===== design/itrt_ctrl.sv =====
module itrt_ctrl #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  itrt_pkg::status_t status,
    output itrt_pkg::cmd_t    cmd
);

    localparam int CNT_W = $clog2(VALUE_WIDTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_PUSH,
        ST_SIGN,
        ST_EMIT
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_comb begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        cmd = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    cnt_next = '0;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(VALUE_WIDTH - 1)) begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                cmd.push = 1'b1;
                cnt_next = '0;
                if (!status.quot_zero) begin
                    state_next = ST_DIVIDE;
                end else if (status.negative) begin
                    state_next = ST_SIGN;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_SIGN: begin
                if (status.out_free) begin
                    cmd.emit_sign = 1'b1;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit_digit = 1'b1;
                    if (status.stack_one) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== design/itrt_datapath.sv =====
module itrt_datapath #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  itrt_pkg::cmd_t                cmd,
    output itrt_pkg::status_t             status,
    input  logic [VALUE_WIDTH-1:0]        value,
    input  logic [itrt_pkg::RADIX_W-1:0]  radix,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic [itrt_pkg::SYMBOL_W-1:0] symbol,
    output logic                          last
);

    localparam int RW = itrt_pkg::RADIX_W;
    localparam int DEPTH_W = $clog2(VALUE_WIDTH + 1);

    logic [VALUE_WIDTH-1:0]      mag_reg, mag_next;
    logic [RW-1:0]               base_reg, base_next;
    logic [RW-1:0]               rem_reg, rem_next;
    logic                        neg_reg, neg_next;
    logic [RW-1:0]               stk_reg [VALUE_WIDTH];
    logic [RW-1:0]               stk_next [VALUE_WIDTH];
    logic [DEPTH_W-1:0]          depth_reg, depth_next;
    logic                        valid_reg, valid_next;
    logic [itrt_pkg::SYMBOL_W-1:0] symbol_reg, symbol_next;
    logic                        last_reg, last_next;
    logic [RW:0]                 trial;
    logic                        qbit;

    assign trial = {rem_reg, mag_reg[VALUE_WIDTH-1]};
    assign qbit = (trial >= {1'b0, base_reg});

    always_comb begin
        mag_next = mag_reg;
        base_next = base_reg;
        rem_next = rem_reg;
        neg_next = neg_reg;
        stk_next = stk_reg;
        depth_next = depth_reg;
        valid_next = valid_reg && !m_tready;
        symbol_next = symbol_reg;
        last_next = last_reg;
        if (cmd.load) begin
            neg_next = value[VALUE_WIDTH-1];
            mag_next = value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;
            rem_next = '0;
            if (radix < itrt_pkg::RADIX_MIN || radix > itrt_pkg::RADIX_MAX) begin
                base_next = itrt_pkg::RADIX_DEFAULT;
            end else begin
                base_next = radix;
            end
        end
        if (cmd.step) begin
            mag_next = {mag_reg[VALUE_WIDTH-2:0], qbit};
            rem_next = qbit ? RW'(trial - {1'b0, base_reg}) : trial[RW-1:0];
        end
        if (cmd.push) begin
            stk_next[0] = rem_reg;
            for (int i = 1; i < VALUE_WIDTH; i++) begin
                stk_next[i] = stk_reg[i-1];
            end
            depth_next = depth_reg + 1'b1;
            rem_next = '0;
        end
        if (cmd.emit_sign) begin
            valid_next = 1'b1;
            symbol_next = itrt_pkg::CHAR_MINUS;
            last_next = 1'b0;
        end
        if (cmd.emit_digit) begin
            valid_next = 1'b1;
            symbol_next = itrt_pkg::digit_to_ascii(stk_reg[0]);
            last_next = (depth_reg == DEPTH_W'(1));
            for (int i = 0; i < VALUE_WIDTH - 1; i++) begin
                stk_next[i] = stk_reg[i+1];
            end
            stk_next[VALUE_WIDTH-1] = '0;
            depth_next = depth_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            depth_reg <= '0;
            rem_reg <= '0;
            base_reg <= itrt_pkg::RADIX_DEFAULT;
        end else begin
            valid_reg <= valid_next;
            depth_reg <= depth_next;
            rem_reg <= rem_next;
            base_reg <= base_next;
        end
        mag_reg <= mag_next;
        neg_reg <= neg_next;
        stk_reg <= stk_next;
        symbol_reg <= symbol_next;
        last_reg <= last_next;
    end

    assign status.quot_zero = (mag_reg == '0);
    assign status.negative = neg_reg;
    assign status.stack_one = (depth_reg == DEPTH_W'(1));
    assign status.out_free = !valid_reg || m_tready;

    assign m_tvalid = valid_reg;
    assign symbol = symbol_reg;
    assign last = last_reg;

    a_rem_below_base: assert property (@(posedge aclk) disable iff (!aresetn)
        rem_reg < base_reg)
        else $error("division remainder reached the radix");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push |-> depth_reg != DEPTH_W'(VALUE_WIDTH))
        else $error("digit stack overflow");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_digit |-> depth_reg != '0)
        else $error("digit stack underflow");

    a_emit_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_sign || cmd.emit_digit) |-> (!valid_reg || m_tready))
        else $error("character emitted over an unaccepted beat");

endmodule

// ===== design/integer_to_radix_text_core.sv =====
// Converts one signed VALUE_WIDTH-bit integer per input beat into its ASCII text in a radix
// from 2 to 36 (any other radix code means ten), one character per output beat, most
// significant character first: a leading '-' for negatives, then '0'-'9' and 'A'-'Z', with
// m_tlast set on the final character. Each digit comes from a bit-serial restoring divider
// that runs through every bit of the value, after which the digit is pushed onto a stack; once
// the quotient is zero, the characters leave at one per cycle while the sink is ready. The
// block holds one value at a time; s_tready rises again once the last character sits in the
// output register.
module integer_to_radix_text_core #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // value [VALUE_WIDTH-1:0], radix [VALUE_WIDTH+5:VALUE_WIDTH], zero padding
    input  logic [((VALUE_WIDTH + 6 + 7) / 8) * 8 - 1:0] s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // symbol [6:0], zero padding [7]
    output logic [7:0]                             m_tdata,
    output logic                                   m_tlast
);

    itrt_pkg::cmd_t                cmd;
    itrt_pkg::status_t             status;
    logic [itrt_pkg::SYMBOL_W-1:0] symbol;

    itrt_ctrl #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    itrt_datapath #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .value    (s_tdata[VALUE_WIDTH-1:0]),
        .radix    (s_tdata[VALUE_WIDTH+itrt_pkg::RADIX_W-1:VALUE_WIDTH]),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .symbol   (symbol),
        .last     (m_tlast)
    );

    assign m_tdata = {1'b0, symbol};

endmodule
